FILE: rtl/ptc_pkg.sv
// Shared types and codes for the prefix tree count engine.
// No dependencies.
package ptc_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_EXACT  = 2'd1,
		OP_PREFIX = 2'd2,
		OP_KTH    = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_POOL     = 3'd1,
		ST_BAD_SYM  = 3'd2,
		ST_TOO_LONG = 3'd3,
		ST_RANK     = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		B_CLEAR,
		B_IDLE,
		B_STEP,
		B_STEP_RD,
		B_END,
		B_CM_PATH,
		B_CM_RD,
		B_CM_WR,
		B_CM_ERD,
		B_CM_EWR,
		B_RES_RD,
		B_RES_GET,
		B_EMIT,
		K_TOT,
		K_TOT_CHK,
		K_END,
		K_END_CHK,
		K_SCAN,
		K_CHK,
		K_FINAL
	} back_state_t;

	// one classified word handed from front to back
	typedef struct packed {
		logic        kth;
		opcode_t     word_op;
		logic        has;
		logic        last;
		logic [7:0]  sym;
		logic        bad;
		logic [15:0] rank;
	} item_cmd_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

FILE: rtl/prefix_tree_count_engine.sv
// Top level of the prefix tree count engine: front, queue and back.
// Depends on ptc_pkg, ptc_front, ptc_queue, ptc_back.
// After reset the block sweeps its node pool, one node per cycle (NODE_COUNT nodes, 1024 by
// default), and holds s_tready low until done. A character item reads the node's child row,
// then updates the link. An insert's last item does a read-modify-write of the pass count of
// each node on the word's path, root included, then of the end count, then reads the result;
// a lookup's last item reads the count of its node. A kth item scans, per output character,
// the children of each node walked, passing over empty links and skipped children, all bound
// by the single port of the count memory. A two-entry queue lets the front keep taking items
// while the back works, and the output register holds a result while the sink stalls.
module prefix_tree_count_engine #(
	parameter int NODE_COUNT = 1024,
	parameter int ALPHABET   = 26,
	parameter int MAX_DEPTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,      // symbol_offset
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,        // opcode[1:0], char_byte[9:2], rank[25:10]
	input  logic        s_tuser,        // has_char
	input  logic        s_tlast,        // word_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,        // count_out[15:0], sym_out[23:16], status[26:24]
	output logic        m_tuser,        // sym_valid
	output logic        m_tlast         // run_last
);
	ptc_pkg::item_cmd_t  push_cmd, pop_cmd;
	ptc_pkg::back_stat_t stat;
	logic                push, push_ready, pop, pop_valid;
	logic [7:0]          offset;

	ptc_front #(.ALPHABET(ALPHABET)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
		.q_ready(push_ready), .q_push(push), .q_cmd(push_cmd),
		.stat, .offset
	);

	ptc_queue u_queue (
		.clk, .arst_n,
		.push, .push_ready, .push_cmd,
		.pop, .pop_valid, .pop_cmd
	);

	ptc_back #(
		.NODE_COUNT(NODE_COUNT), .ALPHABET(ALPHABET), .MAX_DEPTH(MAX_DEPTH)
	) u_back (
		.clk, .arst_n,
		.q_valid(pop_valid), .q_pop(pop), .q_cmd(pop_cmd),
		.offset, .stat,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);
endmodule

FILE: rtl/ptc_front.sv
// Front end: takes input words, tracks word boundaries, maps characters to symbols.
// Depends on ptc_pkg.
module ptc_front #(
	parameter int ALPHABET = 26
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,
	input  logic                  s_tuser,
	input  logic                  s_tlast,
	input  logic                  q_ready,
	output logic                  q_push,
	output ptc_pkg::item_cmd_t    q_cmd,
	input  ptc_pkg::back_stat_t   stat,
	output logic [7:0]            offset
);
	logic                 in_word_q;
	ptc_pkg::opcode_t     op_q;
	logic [7:0]           offset_q;
	ptc_pkg::opcode_t     op_in;
	logic                 acc;

	assign op_in    = ptc_pkg::opcode_t'(s_tdata[1:0]);
	assign s_tready = q_ready && !stat.clearing;
	assign acc      = s_tvalid && s_tready;
	assign q_push   = acc;
	assign offset   = offset_q;

	always_comb begin
		q_cmd.kth     = !in_word_q && (op_in == ptc_pkg::OP_KTH);
		q_cmd.word_op = in_word_q ? op_q : op_in;
		q_cmd.has     = s_tuser;
		q_cmd.last    = s_tlast;
		q_cmd.sym     = s_tdata[9:2] - offset_q;
		q_cmd.bad     = {1'b0, q_cmd.sym} >= 9'(ALPHABET);
		q_cmd.rank    = s_tdata[25:10];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q <= 1'b0;
			op_q      <= ptc_pkg::OP_INSERT;
			offset_q  <= 8'd97;
		end else begin
			if (cfg_we) begin
				offset_q <= cfg_wdata;
			end
			if (acc && !q_cmd.kth) begin
				in_word_q <= !s_tlast;
				op_q      <= q_cmd.word_op;
			end
		end
	end
endmodule

FILE: rtl/ptc_queue.sv
// Two-entry queue of classified words between front and back.
// Depends on ptc_pkg.
module ptc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               push_ready,
	input  ptc_pkg::item_cmd_t push_cmd,
	input  logic               pop,
	output logic               pop_valid,
	output ptc_pkg::item_cmd_t pop_cmd
);
	ptc_pkg::item_cmd_t slot_q [2];
	logic               wr_q;
	logic               rd_q;
	logic [1:0]         fill_q;

	assign push_ready = fill_q != 2'd2;
	assign pop_valid  = fill_q != 2'd0;
	assign pop_cmd    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push && push_ready) begin
				wr_q <= !wr_q;
			end
			if (pop && pop_valid) begin
				rd_q <= !rd_q;
			end
			fill_q <= fill_q + 2'(push && push_ready) - 2'(pop && pop_valid);
		end
	end
endmodule

FILE: rtl/ptc_back.sv
// Back end: node pool memories, word walk, count commit and kth walk; drives the output word.
// Depends on ptc_pkg.
module ptc_back #(
	parameter int NODE_COUNT = 1024,
	parameter int ALPHABET   = 26,
	parameter int MAX_DEPTH  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  ptc_pkg::item_cmd_t  q_cmd,
	input  logic [7:0]          offset,
	output ptc_pkg::back_stat_t stat,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic                m_tuser,
	output logic                m_tlast
);
	localparam int NW  = $clog2(NODE_COUNT);
	localparam int NUW = $clog2(NODE_COUNT + 1);
	localparam int DW  = $clog2(MAX_DEPTH + 1);
	localparam int SYW = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
	localparam int LIM = (MAX_DEPTH < 32) ? MAX_DEPTH : 32;

	// memories
	logic [NW-1:0] link_mem [NODE_COUNT][ALPHABET];
	logic [15:0]   pass_mem [NODE_COUNT];
	logic [15:0]   end_mem  [NODE_COUNT];
	logic [NW-1:0] path_mem [MAX_DEPTH+1];

	logic [NW-1:0] row_q [ALPHABET];
	logic [15:0]   pass_rd_q, end_rd_q;
	logic [NW-1:0] path_rd_q;

	ptc_pkg::back_state_t state_q, state_d;
	ptc_pkg::item_cmd_t   cmd_q;
	logic [NW-1:0]        node_q;
	logic [DW-1:0]        depth_q, idx_q;
	logic                 dead_q;
	ptc_pkg::status_t     err_q;
	logic [NUW-1:0]       nodes_q;
	logic [NW-1:0]        clr_q, cm_node_q, child_q;
	logic [15:0]          k_q, res_cnt_q;
	logic [SYW-1:0]       scan_q, pend_sym_q;
	logic [5:0]           n_q;
	logic                 pend_q;
	ptc_pkg::status_t     kst_q;

	logic                 out_valid_q;
	logic [31:0]          out_data_q;
	logic                 out_user_q, out_last_q;

	// memory controls
	logic                 row_re, cnt_re, path_re;
	logic [NW-1:0]        row_ra, cnt_ra, link_wa, cnt_wa;
	logic [DW-1:0]        path_ra, path_wa;
	logic                 link_we, pass_we, end_we, path_we;
	logic [SYW-1:0]       link_ws;
	logic [NW-1:0]        link_wd, path_wd;
	logic [15:0]          cnt_wd;

	logic                 slot_free, out_we, out_user, out_last;
	logic [31:0]          out_data;

	logic [SYW-1:0]       sym_idx;
	logic [NW-1:0]        link_cur, kc, cm_p;
	logic                 full, advance, k_le_end, k_le_pass;

	assign slot_free = !out_valid_q || m_tready;
	assign sym_idx   = cmd_q.sym[SYW-1:0];
	assign link_cur  = row_q[sym_idx];
	assign kc        = row_q[scan_q];
	assign full      = nodes_q >= NUW'(NODE_COUNT);
	assign advance   = (link_cur != '0) || (cmd_q.word_op == ptc_pkg::OP_INSERT && !full);
	assign cm_p      = (idx_q == '0) ? '0 : path_rd_q;
	assign k_le_end  = k_q <= end_rd_q;
	assign k_le_pass = k_q <= pass_rd_q;
	assign stat.clearing = state_q == ptc_pkg::B_CLEAR;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptc_pkg::B_CLEAR: begin
				if (clr_q == NW'(NODE_COUNT - 1)) state_d = ptc_pkg::B_IDLE;
			end
			ptc_pkg::B_IDLE: begin
				if (q_valid) begin
					if (q_cmd.kth) state_d = ptc_pkg::K_TOT;
					else if (q_cmd.has && !dead_q) state_d = ptc_pkg::B_STEP;
					else if (q_cmd.last) state_d = ptc_pkg::B_END;
				end
			end
			ptc_pkg::B_STEP: begin
				if (!cmd_q.bad && depth_q < DW'(MAX_DEPTH)) state_d = ptc_pkg::B_STEP_RD;
				else if (cmd_q.last) state_d = ptc_pkg::B_END;
				else state_d = ptc_pkg::B_IDLE;
			end
			ptc_pkg::B_STEP_RD: begin
				state_d = cmd_q.last ? ptc_pkg::B_END : ptc_pkg::B_IDLE;
			end
			ptc_pkg::B_END: begin
				if (cmd_q.word_op == ptc_pkg::OP_INSERT)
					state_d = (err_q == ptc_pkg::ST_OK) ? ptc_pkg::B_CM_PATH : ptc_pkg::B_RES_RD;
				else
					state_d = dead_q ? ptc_pkg::B_EMIT : ptc_pkg::B_RES_RD;
			end
			ptc_pkg::B_CM_PATH: state_d = ptc_pkg::B_CM_RD;
			ptc_pkg::B_CM_RD:   state_d = ptc_pkg::B_CM_WR;
			ptc_pkg::B_CM_WR: begin
				state_d = (idx_q == depth_q) ? ptc_pkg::B_CM_ERD : ptc_pkg::B_CM_PATH;
			end
			ptc_pkg::B_CM_ERD:  state_d = ptc_pkg::B_CM_EWR;
			ptc_pkg::B_CM_EWR:  state_d = ptc_pkg::B_RES_RD;
			ptc_pkg::B_RES_RD:  state_d = ptc_pkg::B_RES_GET;
			ptc_pkg::B_RES_GET: state_d = ptc_pkg::B_EMIT;
			ptc_pkg::B_EMIT: begin
				if (slot_free) state_d = ptc_pkg::B_IDLE;
			end
			ptc_pkg::K_TOT: state_d = ptc_pkg::K_TOT_CHK;
			ptc_pkg::K_TOT_CHK: begin
				if (cmd_q.rank == '0 || cmd_q.rank > pass_rd_q) state_d = ptc_pkg::K_FINAL;
				else state_d = ptc_pkg::K_END;
			end
			ptc_pkg::K_END: state_d = ptc_pkg::K_END_CHK;
			ptc_pkg::K_END_CHK: begin
				if (k_le_end || n_q >= 6'(LIM)) state_d = ptc_pkg::K_FINAL;
				else state_d = ptc_pkg::K_SCAN;
			end
			ptc_pkg::K_SCAN: begin
				if (kc != '0) state_d = ptc_pkg::K_CHK;
				else if (scan_q == SYW'(ALPHABET - 1)) state_d = ptc_pkg::K_FINAL;
			end
			ptc_pkg::K_CHK: begin
				if (k_le_pass) begin
					if (!pend_q || slot_free) state_d = ptc_pkg::K_END;
				end else begin
					state_d = (scan_q == SYW'(ALPHABET - 1)) ? ptc_pkg::K_FINAL : ptc_pkg::K_SCAN;
				end
			end
			ptc_pkg::K_FINAL: begin
				if (slot_free) state_d = ptc_pkg::B_IDLE;
			end
			default: state_d = ptc_pkg::B_IDLE;
		endcase
	end

	// memory and output controls
	always_comb begin
		q_pop   = 1'b0;
		row_re  = 1'b0;
		row_ra  = node_q;
		cnt_re  = 1'b0;
		cnt_ra  = '0;
		path_re = 1'b0;
		path_ra = idx_q;
		link_we = 1'b0;
		link_wa = node_q;
		link_ws = sym_idx;
		link_wd = nodes_q[NW-1:0];
		path_we = 1'b0;
		path_wa = depth_q + 1'b1;
		path_wd = (link_cur == '0) ? nodes_q[NW-1:0] : link_cur;
		pass_we = 1'b0;
		end_we  = 1'b0;
		cnt_wa  = cm_node_q;
		cnt_wd  = sat_inc(pass_rd_q);
		out_we  = 1'b0;
		out_data = {5'd0, err_q, 8'd0, res_cnt_q};
		out_user = 1'b0;
		out_last = 1'b1;
		case (state_q)
			ptc_pkg::B_IDLE: q_pop = q_valid;
			ptc_pkg::B_STEP: row_re = !cmd_q.bad && depth_q < DW'(MAX_DEPTH);
			ptc_pkg::B_STEP_RD: begin
				link_we = (link_cur == '0) && advance;
				path_we = advance;
			end
			ptc_pkg::B_CM_PATH: path_re = 1'b1;
			ptc_pkg::B_CM_RD: begin
				cnt_re = 1'b1;
				cnt_ra = cm_p;
			end
			ptc_pkg::B_CM_WR: pass_we = 1'b1;
			ptc_pkg::B_CM_ERD: begin
				cnt_re = 1'b1;
				cnt_ra = node_q;
			end
			ptc_pkg::B_CM_EWR: begin
				end_we = 1'b1;
				cnt_wa = node_q;
				cnt_wd = sat_inc(end_rd_q);
			end
			ptc_pkg::B_RES_RD: begin
				cnt_re = 1'b1;
				cnt_ra = (cmd_q.word_op == ptc_pkg::OP_INSERT) ? '0 : node_q;
			end
			ptc_pkg::B_EMIT: out_we = slot_free;
			ptc_pkg::K_TOT: cnt_re = 1'b1;
			ptc_pkg::K_END: begin
				cnt_re = 1'b1;
				cnt_ra = node_q;
			end
			ptc_pkg::K_END_CHK: row_re = 1'b1;
			ptc_pkg::K_SCAN: begin
				cnt_re = kc != '0;
				cnt_ra = kc;
			end
			ptc_pkg::K_CHK: begin
				// a new character found: the pending one is not the last
				out_we   = k_le_pass && pend_q && slot_free;
				out_data = {8'd0, offset + 8'(pend_sym_q), 16'd0};
				out_user = 1'b1;
				out_last = 1'b0;
			end
			ptc_pkg::K_FINAL: begin
				out_we   = slot_free;
				out_data = {5'd0, kst_q, pend_q ? offset + 8'(pend_sym_q) : 8'd0, 16'd0};
				out_user = pend_q;
			end
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (state_q == ptc_pkg::B_CLEAR) begin
			link_mem[clr_q] <= '{default: '0};
			pass_mem[clr_q] <= '0;
			end_mem[clr_q]  <= '0;
		end else begin
			if (link_we) link_mem[link_wa][link_ws] <= link_wd;
			if (pass_we) pass_mem[cnt_wa] <= cnt_wd;
			if (end_we)  end_mem[cnt_wa]  <= cnt_wd;
		end
		if (row_re) row_q <= link_mem[row_ra];
		if (cnt_re) begin
			pass_rd_q <= pass_mem[cnt_ra];
			end_rd_q  <= end_mem[cnt_ra];
		end
		if (path_we) path_mem[path_wa] <= path_wd;
		if (path_re) path_rd_q <= path_mem[path_ra];
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptc_pkg::B_CLEAR;
			clr_q       <= '0;
			node_q      <= '0;
			depth_q     <= '0;
			idx_q       <= '0;
			dead_q      <= 1'b0;
			err_q       <= ptc_pkg::ST_OK;
			nodes_q     <= NUW'(1);
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			kst_q       <= ptc_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			if (out_we) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ptc_pkg::B_CLEAR: clr_q <= clr_q + 1'b1;
				ptc_pkg::B_IDLE: begin
					if (q_valid) cmd_q <= q_cmd;
				end
				ptc_pkg::B_STEP: begin
					if (cmd_q.bad) begin
						if (err_q == ptc_pkg::ST_OK) err_q <= ptc_pkg::ST_BAD_SYM;
						dead_q <= 1'b1;
					end else if (depth_q >= DW'(MAX_DEPTH)) begin
						if (err_q == ptc_pkg::ST_OK) err_q <= ptc_pkg::ST_TOO_LONG;
						dead_q <= 1'b1;
					end
				end
				ptc_pkg::B_STEP_RD: begin
					if (advance) begin
						node_q  <= path_wd;
						depth_q <= depth_q + 1'b1;
						if (link_cur == '0) nodes_q <= nodes_q + 1'b1;
					end else begin
						dead_q <= 1'b1;
						if (cmd_q.word_op == ptc_pkg::OP_INSERT && err_q == ptc_pkg::ST_OK)
							err_q <= ptc_pkg::ST_POOL;
					end
				end
				ptc_pkg::B_END: begin
					idx_q     <= '0;
					res_cnt_q <= '0;
				end
				ptc_pkg::B_CM_RD: cm_node_q <= cm_p;
				ptc_pkg::B_CM_WR: idx_q <= idx_q + 1'b1;
				ptc_pkg::B_RES_GET: begin
					res_cnt_q <= (cmd_q.word_op == ptc_pkg::OP_EXACT) ? end_rd_q : pass_rd_q;
				end
				ptc_pkg::B_EMIT: begin
					if (slot_free) begin
						node_q  <= '0;
						depth_q <= '0;
						dead_q  <= 1'b0;
						err_q   <= ptc_pkg::ST_OK;
					end
				end
				ptc_pkg::K_TOT: begin
					node_q <= '0;
					n_q    <= '0;
					pend_q <= 1'b0;
					k_q    <= cmd_q.rank;
					kst_q  <= ptc_pkg::ST_RANK;
				end
				ptc_pkg::K_TOT_CHK: begin
					// rank in range: clear the out-of-range status preset above
					if (cmd_q.rank != '0 && cmd_q.rank <= pass_rd_q) kst_q <= ptc_pkg::ST_OK;
				end
				ptc_pkg::K_END_CHK: begin
					k_q    <= k_q - end_rd_q;
					scan_q <= '0;
					if (!k_le_end && n_q >= 6'(LIM)) kst_q <= ptc_pkg::ST_RANK;
				end
				ptc_pkg::K_SCAN: begin
					child_q <= kc;
					if (kc == '0) begin
						if (scan_q == SYW'(ALPHABET - 1)) kst_q <= ptc_pkg::ST_RANK;
						else scan_q <= scan_q + 1'b1;
					end
				end
				ptc_pkg::K_CHK: begin
					if (k_le_pass) begin
						if (!pend_q || slot_free) begin
							pend_q     <= 1'b1;
							pend_sym_q <= scan_q;
							n_q        <= n_q + 1'b1;
							node_q     <= child_q;
						end
					end else begin
						k_q <= k_q - pass_rd_q;
						if (scan_q == SYW'(ALPHABET - 1)) kst_q <= ptc_pkg::ST_RANK;
						else scan_q <= scan_q + 1'b1;
					end
				end
				ptc_pkg::K_FINAL: begin
					if (slot_free) begin
						node_q <= '0;
						pend_q <= 1'b0;
					end
				end
				default: ;
			endcase
			if (out_we) begin
				out_data_q <= out_data;
				out_user_q <= out_user;
				out_last_q <= out_last;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !out_we)
		else $error("result overwritten while stalled");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_q <= NUW'(NODE_COUNT) && nodes_q != '0)
		else $error("node count out of range");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptc_pkg::B_CLEAR |-> !q_pop && !out_we)
		else $error("activity during clearing pass");

endmodule

FILE: sim/tb_prefix_tree_count_engine.sv
// Testbench for prefix_tree_count_engine: drives words and kth queries on the input stream,
// predicts each result word with a behavioral trie model and checks the output stream.
// Depends on ptc_pkg and the engine RTL.
module tb_prefix_tree_count_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 1024;
	localparam int ALPHA = 26;
	localparam int DEPTH = 32;
	localparam int WATCH_LIMIT = 20000;

	typedef struct {
		ptc_pkg::opcode_t op;
		logic [7:0]       ch;
		logic             has;
		logic             last;
		logic [15:0]      rank;
	} in_word_t;

	typedef struct {
		logic [15:0]      cnt;
		logic [7:0]       sym;
		logic             sym_ok;
		ptc_pkg::status_t st;
		logic             last;
	} out_word_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [7:0] cfg_wdata = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [31:0] s_tdata = 0;
	logic s_tuser = 0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [31:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	prefix_tree_count_engine u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	// trie model state
	logic [9:0]       links[NODES*ALPHA];
	logic [15:0]      pass_cnt[NODES];
	logic [15:0]      end_cnt[NODES];
	int               used;
	int               cur_node, cur_depth, cur_err;
	bit               dead, open_word;
	ptc_pkg::opcode_t cur_op;
	int               trail[DEPTH+1];
	logic [7:0]       offset;

	in_word_t  pending[$];
	out_word_t results_due[$];
	int errors = 0;
	int send_idle = 16, recv_idle = 52;
	int quiet = 0;

	initial forever #2 clk = ~clk;

	function automatic void sat_inc(ref logic [15:0] c);
		if (c != 16'hFFFF) c = c + 16'd1;
	endfunction

	function automatic void latch_err(int code);
		if (cur_err == 0) cur_err = code;
		dead = 1;
	endfunction

	function automatic out_word_t mk(int cnt, int sym, bit v, int st, bit l);
		out_word_t r;
		r.cnt = 16'(cnt); r.sym = 8'(sym); r.sym_ok = v;
		r.st = ptc_pkg::status_t'(st); r.last = l;
		return r;
	endfunction

	function automatic void expect_word(out_word_t r);
		results_due = {results_due, r};
	endfunction

	function automatic void walk_char(logic [7:0] ch);
		logic [7:0] s;
		int nx;
		s = ch - offset;
		if (s >= ALPHA) begin
			latch_err(ptc_pkg::ST_BAD_SYM);
			return;
		end
		if (cur_depth >= DEPTH) begin
			latch_err(ptc_pkg::ST_TOO_LONG);
			return;
		end
		nx = links[cur_node*ALPHA+s];
		if (nx == 0) begin
			if (cur_op != ptc_pkg::OP_INSERT) begin
				dead = 1;
				return;
			end
			if (used >= NODES) begin
				latch_err(ptc_pkg::ST_POOL);
				return;
			end
			nx = used;
			used++;
			links[cur_node*ALPHA+s] = 10'(nx);
		end
		cur_node = nx;
		cur_depth++;
		trail[cur_depth] = nx;
	endfunction

	function automatic void kth_walk(int rank);
		int node, k, n, st, c;
		bit found;
		out_word_t r;
		node = 0; k = rank; n = 0; st = 0;
		if (rank == 0 || rank > pass_cnt[0]) begin
			expect_word(mk(0, 0, 0, ptc_pkg::ST_RANK, 1));
			return;
		end
		forever begin
			if (k <= end_cnt[node]) break;
			k -= end_cnt[node];
			if (n >= DEPTH) begin
				st = ptc_pkg::ST_RANK;
				break;
			end
			found = 0;
			for (int i = 0; i < ALPHA; i++) begin
				c = links[node*ALPHA+i];
				if (c == 0) continue;
				if (k <= pass_cnt[c]) begin
					expect_word(mk(0, offset + i, 1, ptc_pkg::ST_OK, 0));
					n++;
					node = c;
					found = 1;
					break;
				end
				k -= pass_cnt[c];
			end
			if (!found) begin
				st = ptc_pkg::ST_RANK;
				break;
			end
		end
		if (n == 0) expect_word(mk(0, 0, 0, st, 1));
		else begin
			r = results_due.pop_back();
			r.st = ptc_pkg::status_t'(st);
			r.last = 1;
			expect_word(r);
		end
	endfunction

	function automatic void predict(in_word_t w);
		int cnt;
		cnt = 0;
		if (!open_word) begin
			if (w.op == ptc_pkg::OP_KTH) begin
				kth_walk(w.rank);
				return;
			end
			open_word = 1;
			cur_op = w.op;
		end
		if (w.has && !dead) walk_char(w.ch);
		if (!w.last) return;
		if (cur_op == ptc_pkg::OP_INSERT) begin
			if (cur_err == 0) begin
				for (int i = 0; i <= cur_depth; i++) sat_inc(pass_cnt[trail[i]]);
				sat_inc(end_cnt[cur_node]);
			end
			cnt = pass_cnt[0];
		end else if (!dead) begin
			cnt = (cur_op == ptc_pkg::OP_EXACT) ? end_cnt[cur_node] : pass_cnt[cur_node];
		end
		expect_word(mk(cnt, 0, 0, cur_err, 1));
		cur_node = 0; cur_depth = 0; dead = 0; cur_err = 0; open_word = 0;
	endfunction

	// queue a whole word; op rides on the first item only, later opcodes random
	task automatic add_word(ptc_pkg::opcode_t op, string txt, bit empty_tail = 0);
		in_word_t w;
		int n;
		n = txt.len();
		for (int i = 0; i < n; i++) begin
			w.op = (i == 0) ? op : ptc_pkg::opcode_t'($urandom_range(0, 3));
			w.ch = txt[i]; w.has = 1; w.last = (i == n - 1) && !empty_tail;
			w.rank = 16'($urandom);
			pending = {pending, w};
		end
		if (n == 0 || empty_tail) begin
			w.op = (n == 0) ? op : ptc_pkg::opcode_t'($urandom_range(0, 3));
			w.ch = 8'($urandom); w.has = 0; w.last = 1; w.rank = 16'($urandom);
			pending = {pending, w};
		end
	endtask

	task automatic add_kth(int rank);
		in_word_t w;
		w.op = ptc_pkg::OP_KTH; w.ch = 8'($urandom); w.has = 1'($urandom_range(0, 1));
		w.last = 1'($urandom_range(0, 1)); w.rank = 16'(rank);
		pending = {pending, w};
	endtask

	function automatic string rand_text(int maxlen, bit noisy);
		string s, t;
		int n;
		logic [7:0] b;
		s = "";
		t = " ";
		n = $urandom_range(1, maxlen);
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 9) == 0) b = 8'($urandom);
			else b = 8'(offset + $urandom_range(0, 4));
			t[0] = b;
			s = {s, t};
		end
		return s;
	endfunction

	task automatic random_phase(int items);
		int r;
		repeat (items) begin
			r = $urandom_range(0, 9);
			if (r < 4) add_word(ptc_pkg::OP_INSERT, rand_text(5, 1), $urandom_range(0, 5) == 0);
			else if (r < 6) add_word(ptc_pkg::OP_EXACT, rand_text(5, 1));
			else if (r < 7) add_word(ptc_pkg::OP_PREFIX, rand_text(3, 1));
			else add_kth($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 30));
		end
	endtask

	task automatic wait_drain();
		wait (pending.size() == 0 && !s_tvalid && results_due.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_offset(logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		offset = v;
	endtask

	// driver
	always @(posedge clk) begin
		if (!s_tvalid || s_tready) begin
			if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
				in_word_t w;
				w = pending.pop_front();
				predict(w);
				s_tdata <= {6'd0, w.rank, w.ch, w.op};
				s_tuser <= w.has;
				s_tlast <= w.last;
				s_tvalid <= 1;
			end else begin
				s_tvalid <= 0;
			end
		end
		m_tready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			out_word_t e;
			if (results_due.size() == 0) begin
				$error("unexpected result word %h", m_tdata);
				errors++;
			end else begin
				e = results_due.pop_front();
				if (m_tdata[15:0] != e.cnt) begin
					$error("count_out exp %0d got %0d", e.cnt, m_tdata[15:0]); errors++;
				end
				if (m_tdata[23:16] != e.sym) begin
					$error("sym_out exp %0d got %0d", e.sym, m_tdata[23:16]); errors++;
				end
				if (m_tuser != e.sym_ok) begin
					$error("sym_valid exp %0d got %0d", e.sym_ok, m_tuser); errors++;
				end
				if (m_tdata[26:24] != e.st) begin
					$error("status exp %0d got %0d", e.st, m_tdata[26:24]); errors++;
				end
				if (m_tlast != e.last) begin
					$error("run_last exp %0d got %0d", e.last, m_tlast); errors++;
				end
			end
		end
	end

	// watchdog on stalled handshakes; reset clearing sweep is far below the limit
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCH_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NODES*ALPHA; i++) links[i] = 0;
		for (int i = 0; i < NODES; i++) begin
			pass_cnt[i] = 0;
			end_cnt[i] = 0;
		end
		used = 1; cur_node = 0; cur_depth = 0; cur_err = 0; dead = 0; open_word = 0;
		cur_op = ptc_pkg::OP_INSERT; trail[0] = 0; offset = 97;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed: all ops, empty word, bad symbol, too long, rank edges, sym extremes
		add_kth(1);
		add_word(ptc_pkg::OP_INSERT, "");
		add_word(ptc_pkg::OP_INSERT, "abc");
		add_word(ptc_pkg::OP_INSERT, "abd");
		add_word(ptc_pkg::OP_INSERT, "z", 1);
		add_word(ptc_pkg::OP_INSERT, "a{");
		add_word(ptc_pkg::OP_EXACT, "abc");
		add_word(ptc_pkg::OP_PREFIX, "ab");
		add_word(ptc_pkg::OP_EXACT, "ax");
		add_word(ptc_pkg::OP_PREFIX, "");
		add_word(ptc_pkg::OP_INSERT, "aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa");
		add_kth(0);
		add_kth(1);
		add_kth(3);
		add_kth(65535);
		wait_drain();

		// symbol index wraps modulo 256 below the offset
		write_offset(8'hFF);
		add_word(ptc_pkg::OP_INSERT, string'({8'hFF, 8'h05, 8'h18}));
		add_word(ptc_pkg::OP_PREFIX, string'({8'hFF, 8'h05}));
		add_kth(2);
		random_phase(6);
		wait_drain();

		write_offset(8'h41);
		send_idle = 52; recv_idle = 16;
		random_phase(6);
		wait_drain();

		write_offset(8'd97);
		send_idle = 0; recv_idle = 0;
		random_phase(6);
		wait_drain();

		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
